>>> design/pfla_pkg.sv
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types and codes for the page free-list allocator.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int PAGE_W     = 10;
    localparam int TABLE_ID_W = 3;
    localparam int STATUS_W   = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_POP,
        ST_GROW
    } pfla_state_t;

endpackage

>>> design/page_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_free_list_allocator
// Per-table page allocator with free lists kept in a link memory.
// ----------------------------------------------------------------------------
// Free and error requests get their done strobe from the lookup state.
// An allocation from a nonempty list does a table read, then a link read,
// and reports from the pop state. A growing allocation reports from lookup
// and stays busy as it chains the new pages through the single link port.
// Reset clears the table valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_free_list_allocator #(
    parameter int TABLES    = 8,
    parameter int MAX_PAGES = 1024,
    parameter int GROW      = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             op,
    input  logic [pfla_pkg::TABLE_ID_W-1:0]  table_id,
    input  logic [pfla_pkg::PAGE_W-1:0]      page_number,
    output logic                             done,
    output logic [pfla_pkg::PAGE_W-1:0]      page_number_res,
    output logic [pfla_pkg::STATUS_W-1:0]    status
);

    localparam int TW   = (TABLES > 1) ? $clog2(TABLES) : 1;
    localparam int PW   = $clog2(MAX_PAGES);
    localparam int CW   = $clog2(MAX_PAGES + 1);
    localparam int SW   = $clog2(MAX_PAGES + GROW + 1);
    localparam int CMPW = (SW > pfla_pkg::PAGE_W) ? SW : pfla_pkg::PAGE_W;
    localparam int AW   = TW + PW;

    function automatic logic [TW-1:0] tbl_mod(input logic [pfla_pkg::TABLE_ID_W-1:0] v);
        logic [7:0] r;
        r = 8'(v);
        for (int i = 0; i < 8; i++)
        begin
            if (r >= 8'(TABLES))
            begin
                r = r - 8'(TABLES);
            end
        end
        return r[TW-1:0];
    endfunction

    pfla_pkg::pfla_state_t state_reg, state_next;

    logic                          op_reg, op_next;
    logic [TW-1:0]                 tbl_reg, tbl_next;
    logic [pfla_pkg::PAGE_W-1:0]   page_reg, page_next;
    logic [PW-1:0]                 ptr_reg, ptr_next;
    logic [PW-1:0]                 last_reg, last_next;
    logic                          done_reg, done_next;
    logic [pfla_pkg::PAGE_W-1:0]   res_reg, res_next;
    logic [pfla_pkg::STATUS_W-1:0] status_reg, status_next;

    logic          tbl_rd_en;
    logic [TW-1:0] tbl_rd_addr;
    logic [PW-1:0] rd_head;
    logic [CW-1:0] rd_count;
    logic          tbl_wr_en;
    logic [PW-1:0] tbl_wr_head;
    logic [CW-1:0] tbl_wr_count;

    logic [AW-1:0] link_addr;
    logic          link_rd_en;
    logic          link_wr_en;
    logic [PW-1:0] link_wr_data;
    logic [PW-1:0] link_rd_data;

    logic [SW-1:0]   grow_sum;
    logic [CMPW-1:0] page_cmp;
    logic [CMPW-1:0] count_cmp;
    logic [CMPW-1:0] head_cmp;
    logic [CMPW-1:0] link_cmp;
    logic [CMPW-1:0] count_res_cmp;

    pfla_table_store #(
        .TABLES (TABLES),
        .TW     (TW),
        .PW     (PW),
        .CW     (CW)
    ) u_table_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .rd_head  (rd_head),
        .rd_count (rd_count),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_reg),
        .wr_head  (tbl_wr_head),
        .wr_count (tbl_wr_count)
    );

    pfla_link_store #(
        .AW (AW),
        .PW (PW)
    ) u_link_store (
        .clk     (clk),
        .addr    (link_addr),
        .rd_en   (link_rd_en),
        .wr_en   (link_wr_en),
        .wr_data (link_wr_data),
        .rd_data (link_rd_data)
    );

    assign grow_sum      = SW'(rd_count) + SW'(GROW);
    assign page_cmp      = CMPW'(page_reg);
    assign count_cmp     = CMPW'(rd_count);
    assign head_cmp      = CMPW'(rd_head);
    assign link_cmp      = CMPW'(link_rd_data);
    assign count_res_cmp = CMPW'(rd_count);
    assign tbl_rd_addr   = tbl_mod(table_id);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pfla_pkg::ST_IDLE;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        tbl_reg    <= tbl_next;
        page_reg   <= page_next;
        ptr_reg    <= ptr_next;
        last_reg   <= last_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        tbl_next     = tbl_reg;
        page_next    = page_reg;
        ptr_next     = ptr_reg;
        last_next    = last_reg;
        done_next    = 1'b0;
        res_next     = '0;
        status_next  = pfla_pkg::STATUS_OK;
        tbl_rd_en    = 1'b0;
        tbl_wr_en    = 1'b0;
        tbl_wr_head  = rd_head;
        tbl_wr_count = rd_count;
        link_addr    = {tbl_reg, ptr_reg};
        link_rd_en   = 1'b0;
        link_wr_en   = 1'b0;
        link_wr_data = '0;

        case (state_reg)
            pfla_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    tbl_rd_en  = 1'b1;
                    op_next    = op;
                    tbl_next   = tbl_rd_addr;
                    page_next  = page_number;
                    state_next = pfla_pkg::ST_LOOKUP;
                end
            end
            pfla_pkg::ST_LOOKUP:
            begin
                state_next = pfla_pkg::ST_IDLE;
                if (op_reg == pfla_pkg::OP_ALLOC)
                begin
                    if (rd_head != '0)
                    begin
                        link_rd_en = 1'b1;
                        link_addr  = {tbl_reg, rd_head};
                        state_next = pfla_pkg::ST_POP;
                    end
                    else if (grow_sum > SW'(MAX_PAGES))
                    begin
                        done_next   = 1'b1;
                        status_next = pfla_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        res_next     = count_res_cmp[pfla_pkg::PAGE_W-1:0];
                        tbl_wr_en    = 1'b1;
                        tbl_wr_head  = PW'(rd_count) + PW'(1);
                        tbl_wr_count = CW'(grow_sum);
                        ptr_next     = PW'(rd_count) + PW'(1);
                        last_next    = PW'(grow_sum - SW'(1));
                        state_next   = pfla_pkg::ST_GROW;
                    end
                end
                else
                begin
                    done_next = 1'b1;
                    if ((page_reg == '0) || (page_cmp >= count_cmp))
                    begin
                        status_next = pfla_pkg::STATUS_BAD;
                    end
                    else
                    begin
                        link_wr_en   = 1'b1;
                        link_addr    = {tbl_reg, page_cmp[PW-1:0]};
                        link_wr_data = rd_head;
                        tbl_wr_en    = 1'b1;
                        tbl_wr_head  = page_cmp[PW-1:0];
                    end
                end
            end
            pfla_pkg::ST_POP:
            begin
                done_next   = 1'b1;
                res_next    = head_cmp[pfla_pkg::PAGE_W-1:0];
                tbl_wr_en   = 1'b1;
                tbl_wr_head = link_cmp[PW-1:0];
                state_next  = pfla_pkg::ST_IDLE;
            end
            pfla_pkg::ST_GROW:
            begin
                link_wr_en = 1'b1;
                ptr_next   = ptr_reg + PW'(1);
                if (ptr_reg == last_reg)
                begin
                    link_wr_data = '0;
                    state_next   = pfla_pkg::ST_IDLE;
                end
                else
                begin
                    link_wr_data = ptr_reg + PW'(1);
                end
            end
            default:
            begin
                state_next = pfla_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != pfla_pkg::ST_IDLE);
    assign done            = done_reg;
    assign page_number_res = res_reg;
    assign status          = status_reg;

`ifndef ASSERT_OFF
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == pfla_pkg::ST_LOOKUP ||
                      $past(state_reg) == pfla_pkg::ST_POP))
        else $error("result strobe without a lookup or pop");

    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == pfla_pkg::ST_LOOKUP))
        else $error("accepted word did not start a lookup");

    a_error_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != pfla_pkg::STATUS_OK) |-> (res_reg == '0))
        else $error("error result carries a page number");

    a_grow_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfla_pkg::ST_GROW) |-> (ptr_reg <= last_reg))
        else $error("growth pointer ran past the last new page");

    a_pop_reads_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pfla_pkg::ST_POP) |-> $past(link_rd_en))
        else $error("pop without a link read");
`endif

endmodule

>>> design/pfla_table_store.sv
// ----------------------------------------------------------------------------
// pfla_table_store
// Per-table memory of free-list head and page count, one entry per table.
// Entries never written read as an empty list with only the header page.
// ----------------------------------------------------------------------------
module pfla_table_store #(
    parameter int TABLES = 8,
    parameter int TW     = 3,
    parameter int PW     = 10,
    parameter int CW     = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [TW-1:0] rd_addr,
    output logic [PW-1:0] rd_head,
    output logic [CW-1:0] rd_count,
    input  logic          wr_en,
    input  logic [TW-1:0] wr_addr,
    input  logic [PW-1:0] wr_head,
    input  logic [CW-1:0] wr_count
);

    localparam int EW = PW + CW;

    logic [EW-1:0]     table_mem [0:TABLES-1];
    logic [TABLES-1:0] valid_reg;
    logic              rd_valid_reg;
    logic [EW-1:0]     rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= {wr_head, wr_count};
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_comb
    begin
        if (rd_valid_reg)
        begin
            rd_head  = rd_data_reg[EW-1:CW];
            rd_count = rd_data_reg[CW-1:0];
        end
        else
        begin
            rd_head  = '0;
            rd_count = CW'(1);
        end
    end

endmodule

>>> design/pfla_link_store.sv
// ----------------------------------------------------------------------------
// pfla_link_store
// Single-port link memory holding the next free page of every page.
// ----------------------------------------------------------------------------
module pfla_link_store #(
    parameter int AW = 13,
    parameter int PW = 10
) (
    input  logic          clk,
    input  logic [AW-1:0] addr,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [PW-1:0] wr_data,
    output logic [PW-1:0] rd_data
);

    localparam int DEPTH = 2 ** AW;

    logic [PW-1:0] link_mem [0:DEPTH-1];
    logic [PW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= link_mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page free-list allocator. A table of directed
// words covers the list edges, bad frees, double frees and one table grown
// until it is full. About four hundred random allocate and free words follow,
// with random idle bursts. Each reply is compared with its directed row's value
// or else with a model of the tables that is updated as each word is accepted.
// ----------------------------------------------------------------------------
module tb;

    localparam int TABLES       = 8;
    localparam int MAX_PAGES    = 1024;
    localparam int GROW         = 16;
    localparam int RANDOM_WORDS = 400;
    localparam int CALM_WORDS   = 80;
    localparam int SCRIPT_LEN   = 23;

    typedef struct {
        logic [pfla_pkg::PAGE_W-1:0]   page;
        logic [pfla_pkg::STATUS_W-1:0] status;
    } reply_t;

    typedef struct {
        logic                            op;
        logic [pfla_pkg::TABLE_ID_W-1:0] tbl;
        logic [pfla_pkg::PAGE_W-1:0]     page;
        int                              reps;
        bit                              known;
        logic [pfla_pkg::PAGE_W-1:0]     want_page;
        logic [pfla_pkg::STATUS_W-1:0]   want_status;
    } script_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            op = pfla_pkg::OP_ALLOC;
    logic [pfla_pkg::TABLE_ID_W-1:0] table_id = '0;
    logic [pfla_pkg::PAGE_W-1:0]     page_number = '0;
    logic                            busy;
    logic                            done;
    logic [pfla_pkg::PAGE_W-1:0]     page_number_res;
    logic [pfla_pkg::STATUS_W-1:0]   status;

    int          head_of [TABLES];
    int          pages_in [TABLES];
    int          link_of [TABLES][MAX_PAGES];
    int          held_pages [TABLES][$];
    reply_t      replies_due [$];
    int          errors = 0;
    script_row_t script [SCRIPT_LEN];

    page_free_list_allocator #(
        .TABLES    (TABLES),
        .MAX_PAGES (MAX_PAGES),
        .GROW      (GROW)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .table_id        (table_id),
        .page_number     (page_number),
        .done            (done),
        .page_number_res (page_number_res),
        .status          (status)
    );

    always #5 clk = ~clk;

    task automatic allocate_or_free(input logic o, input int t, input int p,
                                    output reply_t r);
        int head;
        int cnt;
        head = head_of[t];
        cnt = pages_in[t];
        r.page = '0;
        r.status = pfla_pkg::STATUS_OK;
        if (o == pfla_pkg::OP_ALLOC)
        begin
            if (head != 0)
            begin
                head_of[t] = link_of[t][head];
                r.page = head[pfla_pkg::PAGE_W-1:0];
            end
            else if (cnt + GROW > MAX_PAGES)
            begin
                r.status = pfla_pkg::STATUS_FULL;
            end
            else
            begin
                for (int q = cnt + 1; q < cnt + GROW - 1; q++)
                    link_of[t][q] = q + 1;
                link_of[t][cnt + GROW - 1] = 0;
                head_of[t] = cnt + 1;
                pages_in[t] = cnt + GROW;
                r.page = cnt[pfla_pkg::PAGE_W-1:0];
            end
        end
        else if (p == 0 || p >= cnt)
        begin
            r.status = pfla_pkg::STATUS_BAD;
        end
        else
        begin
            link_of[t][p] = head;
            head_of[t] = p;
        end
    endtask

    function automatic int idle_burst(bit calm);
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 12);
    endfunction

    // The word is held on the inputs until an edge sees start high and busy
    // low; the model is advanced at that same edge.
    task automatic send_word(input logic o, input logic [pfla_pkg::TABLE_ID_W-1:0] t,
                             input logic [pfla_pkg::PAGE_W-1:0] p, input int gap,
                             input bit known, input reply_t typed);
        reply_t r;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        table_id <= t;
        page_number <= p;
        do @(posedge clk); while (busy);
        allocate_or_free(o, int'(t), int'(p), r);
        if (o == pfla_pkg::OP_ALLOC && r.status == pfla_pkg::STATUS_OK)
            held_pages[t].push_back(int'(r.page));
        replies_due.push_back(known ? typed : r);
    endtask

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected reply: page %0d status %0d",
                             page_number_res, status);
            end
            else
            begin
                want = replies_due.pop_front();
                if (want.page !== page_number_res || want.status !== status)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected page %0d status %0d, %s",
                                 want.page, want.status,
                                 $sformatf("got page %0d status %0d",
                                           page_number_res, status));
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("** page_free_list_allocator: FAILED **");
        $finish;
    end

    initial
    begin
        reply_t typed;
        logic   o;
        int     t_i;
        int     p_i;
        int     pick;
        int     idx;
        bit     calm;

        for (int k = 0; k < TABLES; k++)
        begin
            head_of[k] = 0;
            pages_in[k] = 1;
        end

        script = '{
            '{pfla_pkg::OP_ALLOC, 3'd0, 10'd0,    1,    1'b1, 10'd1,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd0, 10'd1023, 1,    1'b1, 10'd2,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_FREE,  3'd0, 10'd0,    1,    1'b1, 10'd0,    pfla_pkg::STATUS_BAD},
            '{pfla_pkg::OP_FREE,  3'd0, 10'd17,   1,    1'b1, 10'd0,    pfla_pkg::STATUS_BAD},
            '{pfla_pkg::OP_FREE,  3'd0, 10'd1023, 1,    1'b1, 10'd0,    pfla_pkg::STATUS_BAD},
            '{pfla_pkg::OP_FREE,  3'd0, 10'd1,    1,    1'b1, 10'd0,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd0, 10'd0,    1,    1'b1, 10'd1,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_FREE,  3'd0, 10'd16,   1,    1'b1, 10'd0,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd0, 10'd0,    1,    1'b1, 10'd16,   pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd0, 10'd0,    1,    1'b1, 10'd3,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_FREE,  3'd1, 10'd1,    1,    1'b1, 10'd0,    pfla_pkg::STATUS_BAD},
            '{pfla_pkg::OP_ALLOC, 3'd1, 10'd0,    1,    1'b1, 10'd1,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd7, 10'd0,    1008, 1'b0, 10'd0,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd7, 10'd0,    1,    1'b1, 10'd0,    pfla_pkg::STATUS_FULL},
            '{pfla_pkg::OP_FREE,  3'd7, 10'd1008, 1,    1'b1, 10'd0,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd7, 10'd0,    1,    1'b1, 10'd1008, pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_FREE,  3'd7, 10'd1009, 1,    1'b1, 10'd0,    pfla_pkg::STATUS_BAD},
            '{pfla_pkg::OP_FREE,  3'd7, 10'd1023, 1,    1'b1, 10'd0,    pfla_pkg::STATUS_BAD},
            '{pfla_pkg::OP_FREE,  3'd7, 10'd5,    1,    1'b1, 10'd0,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_FREE,  3'd7, 10'd5,    1,    1'b1, 10'd0,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd7, 10'd0,    1,    1'b1, 10'd5,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd7, 10'd0,    1,    1'b1, 10'd5,    pfla_pkg::STATUS_OK},
            '{pfla_pkg::OP_ALLOC, 3'd6, 10'd0,    1,    1'b1, 10'd1,    pfla_pkg::STATUS_OK}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < SCRIPT_LEN; r++)
        begin
            typed.page = script[r].want_page;
            typed.status = script[r].want_status;
            for (int k = 0; k < script[r].reps; k++)
                send_word(script[r].op, script[r].tbl, script[r].page,
                          idle_burst(1'b0), script[r].known, typed);
        end

        // Most frees return a page that the same table handed out earlier;
        // the rest carry any page number at all.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            calm = n >= RANDOM_WORDS - CALM_WORDS;
            t_i = $urandom_range(0, TABLES - 1);
            p_i = $urandom_range(0, MAX_PAGES - 1);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                o = pfla_pkg::OP_ALLOC;
            end
            else if (pick < 85 && held_pages[t_i].size() != 0)
            begin
                o = pfla_pkg::OP_FREE;
                idx = $urandom_range(0, held_pages[t_i].size() - 1);
                p_i = held_pages[t_i][idx];
                held_pages[t_i].delete(idx);
            end
            else
            begin
                o = pfla_pkg::OP_FREE;
            end
            send_word(o, t_i[pfla_pkg::TABLE_ID_W-1:0], p_i[pfla_pkg::PAGE_W-1:0],
                      idle_burst(calm), 1'b0, typed);
        end
        start <= 1'b0;

        while (replies_due.size() != 0) @(posedge clk);
        repeat (GROW + 8) @(posedge clk);

        if (errors == 0)
            $display("** page_free_list_allocator: PASSED **");
        else
            $display("** page_free_list_allocator: FAILED **");
        $finish;
    end

endmodule

>>> files.f
design/pfla_pkg.sv
design/pfla_table_store.sv
design/pfla_link_store.sv
design/page_free_list_allocator.sv
tb/tb.sv
